### hw/rtl/nq_enum_pkg.sv
// Shared constants for the N-queens solution enumerator.
`timescale 1ns / 1ps

package nq_enum_pkg;

	// Largest board the search storage is built for
	localparam int DefaultMaxSize = 16;
	// Bits of one packed queen row in the result
	localparam int RowBits = 4;
	// Packed row field holds sixteen columns
	localparam int PackedCols = 16;
	localparam int RowsBits = RowBits * PackedCols;
	// Board size register
	localparam int BoardBits = 5;
	localparam logic [BoardBits-1:0] BoardReset = 5'd8;
	// Solution counter, wraps
	localparam int SolBits = 24;
	// Stream widths (whole bytes)
	localparam int InDataBits = 8;
	localparam int OutDataBits = RowsBits + SolBits;

endpackage

### hw/rtl/n_queens_solution_enumerator.sv
// Top level: N-queens enumerator with a one-square-per-cycle backtracking sequencer.
//
// Channel  Dir  Signals                              Beat carries
// s_axis   in   tvalid tready tdata[7:0]             restart in bit 0
// m_axis   out  tvalid tready tdata[87:0] tuser      queen_rows, solution_number; found
// cfg      in   cfg_valid cfg_ready cfg_data[4:0]    board_size
//
// Request steps: start, then one per square tested, one per column whose rows
// run out, one per queen lifted and one when the search runs dry, then done.
// Requests after exhaustion and the empty placement go from start straight to done.
// arst_n clears the search and sets board size 8; a board size write clears it too.
// Requests and config are taken only while idle, config only with no request offered.
// A waiting result does not block the next request; the one after holds until it drains.
`timescale 1ns / 1ps

module n_queens_solution_enumerator #(
	parameter int MAX_SIZE = nq_enum_pkg::DefaultMaxSize
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// request stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [nq_enum_pkg::InDataBits-1:0]  s_axis_tdata,  // [0] restart, [7:1] zero
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [nq_enum_pkg::OutDataBits-1:0] m_axis_tdata,  // [63:0] queen_rows,
	                                                           // [87:64] solution_number
	output logic                                m_axis_tuser,  // [0] found
	// board size write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nq_enum_pkg::BoardBits-1:0]   cfg_data
);

	localparam int RW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int RV = 1 << RW;
	localparam int CW = $clog2(MAX_SIZE + 1);
	localparam int XW = $clog2(2 * MAX_SIZE);
	localparam int XV = 1 << XW;
	localparam int QB = nq_enum_pkg::RowBits;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_START  = 5'b00010,
		ST_SEARCH = 5'b00100,
		ST_BACK   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t                             state_q;
	logic [nq_enum_pkg::BoardBits-1:0]  board_q;
	logic [QB-1:0]                      roq_q [RV];
	logic [RV-1:0]                      row_taken_q;
	logic [XV-1:0]                      rise_q;
	logic [XV-1:0]                      fall_q;
	logic [CW-1:0]                      col_q;
	logic [CW-1:0]                      row_q;
	logic                               exh_q;
	logic                               found_q;
	logic [nq_enum_pkg::SolBits-1:0]    sol_q;
	logic                               m_vld_q;
	logic [nq_enum_pkg::RowsBits-1:0]   m_rows_q;
	logic [nq_enum_pkg::SolBits-1:0]    m_num_q;
	logic                               m_found_q;

	logic                               in_acc;
	logic                               cfg_acc;
	logic                               out_load;
	logic [CW-1:0]                      n;
	logic [CW-1:0]                      col_m;
	logic [QB-1:0]                      roq_rd;
	logic [CW-1:0]                      sel_col;
	logic [CW-1:0]                      sel_row;
	logic [XW-1:0]                      rise_idx;
	logic [XW-1:0]                      fall_idx;
	logic [RV-1:0]                      row_bit;
	logic [XV-1:0]                      rise_bit;
	logic [XV-1:0]                      fall_bit;
	logic                               sq_free;
	logic                               place;
	logic [nq_enum_pkg::RowsBits-1:0]   packed_rows;

	// Handshakes; hold config off while a request is offered
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = (state_q == ST_IDLE) && !s_axis_tvalid;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign out_load      = (state_q == ST_DONE) && (!m_vld_q || m_axis_tready);

	// Clamp the board size to the built storage
	assign n = (board_q > nq_enum_pkg::BoardBits'(MAX_SIZE)) ? CW'(MAX_SIZE) : CW'(board_q);

	// Square under test: current square while searching, last queen while backing up
	assign col_m   = col_q - CW'(1);
	assign roq_rd  = roq_q[col_m[RW-1:0]];
	assign sel_col = (state_q == ST_BACK) ? col_m : col_q;
	assign sel_row = (state_q == ST_BACK) ? CW'(roq_rd) : row_q;

	// Shared occupancy unit: diagonal indices and one-hot masks
	assign rise_idx = XW'(sel_row) + XW'(sel_col);
	assign fall_idx = XW'(n) + XW'(sel_col) - XW'(1) - XW'(sel_row);
	assign row_bit  = RV'(1) << sel_row[RW-1:0];
	assign rise_bit = XV'(1) << rise_idx;
	assign fall_bit = XV'(1) << fall_idx;
	assign sq_free  = !row_taken_q[sel_row[RW-1:0]] && !rise_q[rise_idx] && !fall_q[fall_idx];
	assign place    = (state_q == ST_SEARCH) && (row_q < n) && sq_free;

	// Pack the placed rows, columns beyond the board read zero
	for (genvar c = 0; c < nq_enum_pkg::PackedCols; c++) begin : g_pack
		if (c < MAX_SIZE) begin : g_live
			assign packed_rows[c*QB +: QB] = (CW'(c) < n) ? roq_q[c] : '0;
		end else begin : g_dead
			assign packed_rows[c*QB +: QB] = '0;
		end
	end

	// Queen row store, written on each placement
	always_ff @(posedge clk) begin
		if (place) begin
			roq_q[col_q[RW-1:0]] <= QB'(row_q);
		end
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			board_q     <= nq_enum_pkg::BoardReset;
			row_taken_q <= '0;
			rise_q      <= '0;
			fall_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			exh_q       <= 1'b0;
			found_q     <= 1'b0;
			sol_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_acc || (in_acc && s_axis_tdata[0])) begin
						row_taken_q <= '0;
						rise_q      <= '0;
						fall_q      <= '0;
						col_q       <= '0;
						exh_q       <= 1'b0;
						sol_q       <= '0;
					end
					if (cfg_acc) begin
						board_q <= cfg_data;
					end else if (in_acc) begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					if (exh_q) begin
						found_q <= 1'b0;
						state_q <= ST_DONE;
					end else if (col_q >= n) begin
						if ((sol_q == '0) && (n == '0)) begin
							// empty board: the empty placement once
							found_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							col_q   <= n;
							state_q <= ST_BACK;
						end
					end else begin
						row_q   <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (row_q < n) begin
						if (sq_free) begin
							row_taken_q <= row_taken_q | row_bit;
							rise_q      <= rise_q | rise_bit;
							fall_q      <= fall_q | fall_bit;
							col_q       <= col_q + CW'(1);
							row_q       <= '0;
							if (col_q + CW'(1) == n) begin
								found_q <= 1'b1;
								state_q <= ST_DONE;
							end
						end else begin
							row_q <= row_q + CW'(1);
						end
					end else begin
						state_q <= ST_BACK;
					end
				end
				ST_BACK: begin
					if (col_q == '0) begin
						found_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						// lift the last queen and resume one row below it
						row_taken_q <= row_taken_q & ~row_bit;
						rise_q      <= rise_q & ~rise_bit;
						fall_q      <= fall_q & ~fall_bit;
						col_q       <= col_m;
						row_q       <= CW'(roq_rd) + CW'(1);
						state_q     <= ST_SEARCH;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
						if (found_q) begin
							sol_q <= sol_q + nq_enum_pkg::SolBits'(1);
						end else begin
							exh_q <= 1'b1;
							col_q <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (out_load) begin
			m_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_rows_q  <= found_q ? packed_rows : '0;
			m_num_q   <= found_q ? sol_q + nq_enum_pkg::SolBits'(1) : sol_q;
			m_found_q <= found_q;
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = {m_num_q, m_rows_q};
	assign m_axis_tuser  = m_found_q;

	// Each placed column holds exactly one row and one rising diagonal
	a_rows_match_cols: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(row_taken_q) == int'(col_q))
		else $error("row occupancy does not match placed columns");

	a_rise_match_cols: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(rise_q) == int'(col_q))
		else $error("diagonal occupancy does not match placed columns");

	// An exhausted search keeps no placed columns
	a_exh_empty: assert property (@(posedge clk) disable iff (!arst_n)
		exh_q |-> (col_q == '0))
		else $error("exhausted search still holds queens");

	// Searching stays inside the board
	a_search_in_board: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (col_q < n))
		else $error("search column beyond board");

	// A taken request closes the input until its result is formed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("request taken while busy");

endmodule

### test/queens_check_pkg.sv
// Solution tracker for the N-queens enumerator testbench: search mirror and result checks.
`timescale 1ns / 1ps

package queens_check_pkg;

	localparam int MaxBoard = nq_enum_pkg::DefaultMaxSize;

	// One result beat as the enumerator should deliver it
	typedef struct packed {
		logic [nq_enum_pkg::RowsBits-1:0] queen_rows;
		logic                             found;
		logic [nq_enum_pkg::SolBits-1:0]  solution_number;
	} solution_beat_t;

	class queens_solution_board;
		logic [nq_enum_pkg::BoardBits-1:0] board_size;
		logic [nq_enum_pkg::RowBits-1:0]   row_of_col [MaxBoard];
		logic [15:0]                       rows_used;
		logic [30:0]                       rise_used;
		logic [30:0]                       fall_used;
		int unsigned                       cols_placed;
		bit                                exhausted;
		logic [nq_enum_pkg::SolBits-1:0]   delivered;
		solution_beat_t                    expected_solutions [$];
		int                                mismatches;

		function new();
			board_size = nq_enum_pkg::BoardReset;
			mismatches = 0;
			clear_search();
		endfunction

		// Forget the whole search, as reset and a size write do
		function void clear_search();
			foreach (row_of_col[i])
				row_of_col[i] = '0;
			rows_used   = '0;
			rise_used   = '0;
			fall_used   = '0;
			cols_placed = 0;
			exhausted   = 1'b0;
			delivered   = '0;
		endfunction

		function void set_board_size(logic [nq_enum_pkg::BoardBits-1:0] value);
			board_size = value;
			clear_search();
		endfunction

		// Clamp oversized boards to the storage size
		function int unsigned board_n();
			return (board_size > MaxBoard) ? MaxBoard : board_size;
		endfunction

		function bit square_free(int unsigned r, int unsigned c, int unsigned n);
			return !rows_used[r] && !rise_used[r + c] && !fall_used[n - 1 + c - r];
		endfunction

		function void occupy(int unsigned r, int unsigned c, int unsigned n, bit on);
			rows_used[r]             = on;
			rise_used[r + c]         = on;
			fall_used[n - 1 + c - r] = on;
		endfunction

		// Depth-first step to the next full placement; 0 once the search is spent
		function bit seek_next_placement(int unsigned n);
			int unsigned col;
			int unsigned row;
			bit          back;
			bit          placed;
			col  = cols_placed;
			row  = 0;
			back = 1'b0;
			if (col >= n) begin
				// the empty board counts once as a solution
				if (delivered == 0 && n == 0)
					return 1'b1;
				col  = n;
				back = 1'b1;
			end
			while (1) begin
				placed = 1'b0;
				if (back) begin
					if (col == 0)
						return 1'b0;
					col--;
					row = row_of_col[col];
					occupy(row, col, n, 1'b0);
					row++;
					back = 1'b0;
				end
				while (row < n) begin
					if (square_free(row, col, n)) begin
						row_of_col[col] = row[nq_enum_pkg::RowBits-1:0];
						occupy(row, col, n, 1'b1);
						placed = 1'b1;
						break;
					end
					row++;
				end
				if (!placed) begin
					back = 1'b1;
					continue;
				end
				col++;
				row = 0;
				if (col == n) begin
					cols_placed = col;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		// Work out the answer to one accepted request and queue it
		function void take_request(bit restart);
			int unsigned    n;
			bit             ok;
			solution_beat_t beat;
			n    = board_n();
			ok   = 1'b0;
			beat = '0;
			if (restart)
				clear_search();
			if (!exhausted) begin
				ok = seek_next_placement(n);
				if (ok) begin
					delivered = delivered + 1'b1;
					for (int c = 0; c < n; c++)
						beat.queen_rows[nq_enum_pkg::RowBits*c +: nq_enum_pkg::RowBits] =
							row_of_col[c];
				end else begin
					exhausted   = 1'b1;
					cols_placed = 0;
				end
			end
			beat.found           = ok;
			beat.solution_number = delivered;
			expected_solutions   = {expected_solutions, beat};
		endfunction

		task report_mismatch(string msg);
			$display("ERROR: %s", msg);
			mismatches++;
		endtask

		// Compare one delivered beat with the oldest answer waiting
		task compare_solution(logic [nq_enum_pkg::RowsBits-1:0] rows, logic found,
				logic [nq_enum_pkg::SolBits-1:0] number);
			solution_beat_t want;
			if (expected_solutions.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: rows %h found %0b num %0d",
					rows, found, number));
				return;
			end
			want = expected_solutions.pop_front();
			if (rows !== want.queen_rows)
				report_mismatch($sformatf("queen_rows %h, expected %h", rows, want.queen_rows));
			if (found !== want.found)
				report_mismatch($sformatf("found %b, expected %b", found, want.found));
			if (number !== want.solution_number)
				report_mismatch($sformatf("solution_number %0d, expected %0d",
					number, want.solution_number));
		endtask
	endclass

endpackage

### test/n_queens_solution_enumerator_tb.sv
// Testbench top for the N-queens solution enumerator: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps

module n_queens_solution_enumerator_tb;

	localparam int TotalItems     = 650;
	localparam int QuietTailItems = 90;
	localparam int PressureCycles = 8000;
	localparam int SettleCycles   = 8;
	localparam int DrainCycles    = 50;
	localparam int CycleLimit     = 40000000;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                s_axis_tvalid;
	logic                                s_axis_tready;
	logic [nq_enum_pkg::InDataBits-1:0]  s_axis_tdata;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready;
	logic [nq_enum_pkg::OutDataBits-1:0] m_axis_tdata;
	logic                                m_axis_tuser;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [nq_enum_pkg::BoardBits-1:0]   cfg_data;

	queens_check_pkg::queens_solution_board enumerator_model;
	int                   items_sent = 0;
	bit                   quiet_tail = 1'b0;
	bit                   pressure_armed = 1'b0;
	int unsigned          cycle_count;

	n_queens_solution_enumerator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stop a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Sender-side idle length before the next request beat
	function int request_gap();
		if (quiet_tail)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
	endfunction

	// Offer one request beat and note it once taken
	task automatic send_request(input bit restart);
		int gap;
		gap = request_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(nq_enum_pkg::InDataBits-1){1'b0}}, restart};
		do @(posedge clk); while (!s_axis_tready);
		enumerator_model.take_request(restart);
		items_sent++;
		if (items_sent >= TotalItems - QuietTailItems)
			quiet_tail = 1'b1;
	endtask

	task automatic write_board_size(input logic [nq_enum_pkg::BoardBits-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		enumerator_model.set_board_size(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid and wait until every answer is back
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (enumerator_model.expected_solutions.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Short fixed sequence on one board; bit i of restarts is the restart of beat i
	task automatic board_phase(input logic [nq_enum_pkg::BoardBits-1:0] size,
			input bit write_size, input logic [31:0] restarts, input int count);
		if (write_size)
			write_board_size(size);
		for (int i = 0; i < count; i++)
			send_request(restarts[i]);
		settle();
	endtask

	// Result side: random hold-offs, one long stall on request
	initial begin
		int hold;
		int burst;
		m_axis_tready = 1'b0;
		hold  = 0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (pressure_armed) begin
				pressure_armed = 1'b0;
				hold = PressureCycles;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				m_axis_tready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
				burst = $urandom_range(1, 4) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Check every result beat taken
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			enumerator_model.compare_solution(m_axis_tdata[nq_enum_pkg::RowsBits-1:0],
				m_axis_tuser, m_axis_tdata[nq_enum_pkg::RowsBits +: nq_enum_pkg::SolBits]);
	end

	initial begin
		logic [nq_enum_pkg::BoardBits-1:0] size;
		int                                count;
		int                                pick;
		bit                                first_random;
		enumerator_model = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset size, empty board, single square, boards with no solution,
		// exhaustion with repeated done, restart after done, largest and oversized boards
		board_phase(5'd0, 1'b0, 32'b100, 3);
		board_phase(5'd0, 1'b1, 32'b100, 3);
		board_phase(5'd1, 1'b1, 32'b0, 3);
		board_phase(5'd2, 1'b1, 32'b01, 2);
		board_phase(5'd3, 1'b1, 32'b10, 2);
		board_phase(5'd4, 1'b1, 32'b10000, 5);
		board_phase(5'd16, 1'b1, 32'b0, 1);
		board_phase(5'd31, 1'b1, 32'b0, 2);

		// Random phases, mostly small boards that run to exhaustion
		first_random = 1'b1;
		while (items_sent < TotalItems) begin
			if (first_random) begin
				// hold the result side off long enough to back up the requests
				first_random   = 1'b0;
				size           = 5'd8;
				count          = 40;
				pressure_armed = 1'b1;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 2) begin
					size  = 5'd0;
					count = $urandom_range(1, 3);
				end else if (pick < 4) begin
					size  = nq_enum_pkg::BoardBits'($urandom_range(queens_check_pkg::MaxBoard + 1,
						31));
					count = $urandom_range(1, 2);
				end else if (pick < 8) begin
					size  = nq_enum_pkg::BoardBits'($urandom_range(13,
						queens_check_pkg::MaxBoard));
					count = $urandom_range(1, 2);
				end else if (pick < 28) begin
					size  = nq_enum_pkg::BoardBits'($urandom_range(9, 12));
					count = $urandom_range(2, 12);
				end else begin
					size  = nq_enum_pkg::BoardBits'($urandom_range(1, 8));
					count = $urandom_range(1, 45);
					if (size == 5'd8 && $urandom_range(0, 3) == 0)
						count = $urandom_range(93, 100);
				end
			end
			// keep the total close to the planned item count
			if (count > TotalItems - items_sent)
				count = TotalItems - items_sent;
			write_board_size(size);
			for (int k = 0; k < count; k++)
				send_request($urandom_range(0, 11) == 0);
			settle();
		end

		// Let any stray beat show up, then flag anything left waiting
		repeat (DrainCycles) @(posedge clk);
		if (enumerator_model.expected_solutions.size() != 0)
			enumerator_model.report_mismatch($sformatf("%0d results never arrived",
				enumerator_model.expected_solutions.size()));
		if (enumerator_model.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
hw/rtl/nq_enum_pkg.sv
hw/rtl/n_queens_solution_enumerator.sv
test/queens_check_pkg.sv
test/n_queens_solution_enumerator_tb.sv
